/* design/ttas_pkg.sv */
// ----------------------------------------------------------------------------
// ttas_pkg
// Shared types, constants and helpers for the turret aim and trigger sequencer.
// ----------------------------------------------------------------------------
package ttas_pkg;

  localparam int TIMER_BITS = 11;
  localparam int AIM_MAX    = 180;

  localparam int CFG_TW  = 11;
  localparam int BUSY_W  = 11;
  localparam int CMP_W   = (TIMER_BITS > CFG_TW) ? TIMER_BITS : CFG_TW;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] AIM_MAX_C   = 8'(AIM_MAX);
  localparam logic [7:0] AIM_RESET_C = 8'd90;
  localparam logic [7:0] TRIG_STEP_C = 8'd5;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_UP     = 3'd1,
    PH_HOLD   = 3'd2,
    PH_DOWN   = 3'd3,
    PH_REFUSE = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_LOCKOUT   = 3'd0,
    CFG_MOTION_DEBOUNCE = 3'd1,
    CFG_SWEEP_INTERVAL = 3'd2,
    CFG_MANUAL_STEP    = 3'd3,
    CFG_STROKE_TOP     = 3'd4,
    CFG_STROKE_DWELL   = 3'd5,
    CFG_STROKE_HOLD    = 3'd6,
    CFG_REFUSE_HOLD    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] mode_lockout_ticks;
    logic [10:0] motion_debounce_ticks;
    logic [10:0] sweep_interval_ticks;
    logic [5:0]  manual_step;
    logic [7:0]  stroke_top;
    logic [7:0]  stroke_dwell_ticks;
    logic [10:0] stroke_hold_ticks;
    logic [10:0] refuse_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic mode_button_n;
    logic motion_level;
    logic encoder_a;
    logic encoder_b;
    logic fire_key_n;
  } in_t;

  typedef struct packed {
    logic [7:0] aim_angle;
    logic [7:0] trigger_angle;
    logic       auto_active;
    logic       target_seen;
    logic       busy_res;
    logic       fire_refused;
  } res_t;

  // reload value for one five-degree dwell, a zero dwell counts as one tick
  function automatic logic [BUSY_W-1:0] dwell_reload(input cfg_t cfg);
    logic [7:0] len;
    len = (cfg.stroke_dwell_ticks == 8'd0) ? 8'd1 : cfg.stroke_dwell_ticks;
    return BUSY_W'(len - 8'd1);
  endfunction

endpackage

/* design/ttas_in_if.sv */
// ----------------------------------------------------------------------------
// ttas_in_if
// Tick sample channel: one word per millisecond tick, five pin levels.
// ----------------------------------------------------------------------------
interface ttas_in_if;
  logic valid;
  logic ready;
  logic mode_button_n;
  logic motion_level;
  logic encoder_a;
  logic encoder_b;
  logic fire_key_n;

  modport source (output valid, output mode_button_n, output motion_level,
                  output encoder_a, output encoder_b, output fire_key_n,
                  input ready);
  modport sink   (input valid, input mode_button_n, input motion_level,
                  input encoder_a, input encoder_b, input fire_key_n,
                  output ready);
endinterface

/* design/ttas_out_if.sv */
// ----------------------------------------------------------------------------
// ttas_out_if
// Result channel: servo commands and status flags, one word per tick.
// ----------------------------------------------------------------------------
interface ttas_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] aim_angle;
  logic [7:0] trigger_angle;
  logic       auto_active;
  logic       target_seen;
  logic       busy_res;
  logic       fire_refused;

  modport source (output valid, output aim_angle, output trigger_angle,
                  output auto_active, output target_seen, output busy_res,
                  output fire_refused, input ready);
  modport sink   (input valid, input aim_angle, input trigger_angle,
                  input auto_active, input target_seen, input busy_res,
                  input fire_refused, output ready);
endinterface

/* design/ttas_cfg.sv */
// ----------------------------------------------------------------------------
// ttas_cfg
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module ttas_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [ttas_pkg::CFG_IDX_W-1:0] idx_i,
  input  logic [ttas_pkg::CFG_TW-1:0]    data_i,
  output ttas_pkg::cfg_t            cfg_o
);
  import ttas_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_MODE_LOCKOUT:    cfg_d.mode_lockout_ticks    = data_i;
        CFG_MOTION_DEBOUNCE: cfg_d.motion_debounce_ticks = data_i;
        CFG_SWEEP_INTERVAL:  cfg_d.sweep_interval_ticks  = data_i;
        CFG_MANUAL_STEP:     cfg_d.manual_step           = data_i[5:0];
        CFG_STROKE_TOP:      cfg_d.stroke_top            = data_i[7:0];
        CFG_STROKE_DWELL:    cfg_d.stroke_dwell_ticks    = data_i[7:0];
        CFG_STROKE_HOLD:     cfg_d.stroke_hold_ticks     = data_i;
        CFG_REFUSE_HOLD:     cfg_d.refuse_hold_ticks     = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_lockout_ticks    <= 11'd500;
      cfg_q.motion_debounce_ticks <= 11'd200;
      cfg_q.sweep_interval_ticks  <= 11'd50;
      cfg_q.manual_step           <= 6'd5;
      cfg_q.stroke_top            <= 8'd50;
      cfg_q.stroke_dwell_ticks    <= 8'd15;
      cfg_q.stroke_hold_ticks     <= 11'd100;
      cfg_q.refuse_hold_ticks     <= 11'd300;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

/* design/ttas_stroke.sv */
// ----------------------------------------------------------------------------
// ttas_stroke
// Trigger stroke and refusal hold sequencer: one tick of the busy phase.
// ----------------------------------------------------------------------------
module ttas_stroke (
  input  ttas_pkg::phase_e             phase_i,
  input  logic [ttas_pkg::BUSY_W-1:0]  timer_i,
  input  logic [7:0]                   trig_i,
  input  ttas_pkg::cfg_t               cfg_i,
  output ttas_pkg::phase_e             phase_o,
  output logic [ttas_pkg::BUSY_W-1:0]  timer_o,
  output logic [7:0]                   trig_o
);
  import ttas_pkg::*;

  logic [8:0] trig_up;

  assign trig_up = {1'b0, trig_i} + {1'b0, TRIG_STEP_C};

  always_comb begin
    phase_o = phase_i;
    timer_o = timer_i;
    trig_o  = trig_i;
    if (phase_i != PH_IDLE) begin
      if (timer_i != '0) begin
        timer_o = timer_i - BUSY_W'(1);
      end else begin
        case (phase_i)
          PH_UP: begin
            if (trig_up <= {1'b0, cfg_i.stroke_top}) begin
              trig_o  = trig_up[7:0];
              timer_o = dwell_reload(cfg_i);
            end else if (cfg_i.stroke_hold_ticks != '0) begin
              phase_o = PH_HOLD;
              timer_o = BUSY_W'(cfg_i.stroke_hold_ticks - 11'd1);
            end else begin
              phase_o = PH_DOWN;
              timer_o = dwell_reload(cfg_i);
            end
          end
          PH_HOLD: begin
            phase_o = PH_DOWN;
            timer_o = dwell_reload(cfg_i);
          end
          PH_DOWN: begin
            if (trig_i >= TRIG_STEP_C) begin
              trig_o  = trig_i - TRIG_STEP_C;
              timer_o = dwell_reload(cfg_i);
            end else begin
              trig_o  = '0;
              phase_o = PH_IDLE;
            end
          end
          default: begin
            phase_o = PH_IDLE;
            timer_o = '0;
          end
        endcase
      end
    end
  end
endmodule

/* design/ttas_step.sv */
// ----------------------------------------------------------------------------
// ttas_step
// Loop state and the single pass that one tick sample drives through it.
// ----------------------------------------------------------------------------
module ttas_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  ttas_pkg::in_t  in_i,
  input  ttas_pkg::cfg_t cfg_i,
  output ttas_pkg::res_t res_o
);
  import ttas_pkg::*;

  logic [TIMER_BITS-1:0] ec_mode_q, ec_mode_d, ec_mot_q, ec_mot_d, ec_sw_q, ec_sw_d;
  logic [TIMER_BITS-1:0] ec_mode_inc, ec_mot_inc, ec_sw_inc;
  logic                  auto_q, auto_d, ms_q, ms_d, encp_q, encp_d, up_q, up_d;
  logic [7:0]            aim_q, aim_d, trig_q, trig_d, st_trig;
  phase_e                phase_q, phase_d, st_phase;
  logic [BUSY_W-1:0]     timer_q, timer_d, st_timer;
  logic                  refused, started;
  logic [8:0]            aim_sum;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == '1) ? v : v + TIMER_BITS'(1);
  endfunction

  assign ec_mode_inc = sat_inc(ec_mode_q);
  assign ec_mot_inc  = sat_inc(ec_mot_q);
  assign ec_sw_inc   = sat_inc(ec_sw_q);
  assign aim_sum     = {1'b0, aim_q} + {3'b000, cfg_i.manual_step};

  ttas_stroke u_stroke (
    .phase_i (phase_q),
    .timer_i (timer_q),
    .trig_i  (trig_q),
    .cfg_i   (cfg_i),
    .phase_o (st_phase),
    .timer_o (st_timer),
    .trig_o  (st_trig)
  );

  always_comb begin
    ec_mode_d = ec_mode_inc;
    ec_mot_d  = ec_mot_inc;
    ec_sw_d   = ec_sw_inc;
    phase_d   = st_phase;
    timer_d   = st_timer;
    trig_d    = st_trig;
    auto_d    = auto_q;
    ms_d      = ms_q;
    encp_d    = encp_q;
    aim_d     = aim_q;
    up_d      = up_q;
    refused   = 1'b0;
    started   = 1'b0;

    // a sequence that finishes on this tick leaves the rest of the pass running
    if (st_phase == PH_IDLE) begin
      if (!in_i.mode_button_n &&
          (CMP_W'(ec_mode_inc) > CMP_W'(cfg_i.mode_lockout_ticks))) begin
        ec_mode_d = '0;
        auto_d    = ~auto_q;
      end
      if ((in_i.motion_level != ms_q) &&
          (CMP_W'(ec_mot_inc) > CMP_W'(cfg_i.motion_debounce_ticks))) begin
        ec_mot_d = '0;
        ms_d     = in_i.motion_level;
        if (in_i.motion_level && auto_d) begin
          started = 1'b1;
          phase_d = PH_UP;
          trig_d  = '0;
          timer_d = dwell_reload(cfg_i);
        end
      end
      if (!started) begin
        if (!auto_d) begin
          // detent on the falling edge of channel a
          if ((in_i.encoder_a != encp_q) && !in_i.encoder_a) begin
            if (in_i.encoder_b) begin
              aim_d = (aim_sum > {1'b0, AIM_MAX_C}) ? AIM_MAX_C : aim_sum[7:0];
            end else begin
              aim_d = ({2'b00, cfg_i.manual_step} > aim_q) ? 8'd0
                                                           : aim_q - {2'b00, cfg_i.manual_step};
            end
          end
          encp_d = in_i.encoder_a;
          if (!in_i.fire_key_n) begin
            phase_d = PH_UP;
            trig_d  = '0;
            timer_d = dwell_reload(cfg_i);
          end
        end else begin
          if (CMP_W'(ec_sw_inc) >= CMP_W'(cfg_i.sweep_interval_ticks)) begin
            ec_sw_d = '0;
            if (up_q) begin
              if (aim_q < AIM_MAX_C) aim_d = aim_q + 8'd1;
              if (aim_d >= AIM_MAX_C) up_d = 1'b0;
            end else begin
              if (aim_q != 8'd0) aim_d = aim_q - 8'd1;
              if (aim_d == 8'd0) up_d = 1'b1;
            end
          end
          if (!in_i.fire_key_n) begin
            if (ms_d) begin
              phase_d = PH_UP;
              trig_d  = '0;
              timer_d = dwell_reload(cfg_i);
            end else begin
              refused = 1'b1;
              if (cfg_i.refuse_hold_ticks != '0) begin
                phase_d = PH_REFUSE;
                timer_d = BUSY_W'(cfg_i.refuse_hold_ticks - 11'd1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_mode_q <= '1;
      ec_mot_q  <= '1;
      ec_sw_q   <= '1;
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      trig_q    <= '0;
      auto_q    <= 1'b0;
      ms_q      <= 1'b0;
      encp_q    <= 1'b0;
      aim_q     <= AIM_RESET_C;
      up_q      <= 1'b1;
    end else if (step_i) begin
      ec_mode_q <= ec_mode_d;
      ec_mot_q  <= ec_mot_d;
      ec_sw_q   <= ec_sw_d;
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      trig_q    <= trig_d;
      auto_q    <= auto_d;
      ms_q      <= ms_d;
      encp_q    <= encp_d;
      aim_q     <= aim_d;
      up_q      <= up_d;
    end
  end

  always_comb begin
    res_o.aim_angle     = aim_d;
    res_o.trigger_angle = trig_d;
    res_o.auto_active   = auto_d;
    res_o.target_seen   = ms_d;
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.fire_refused  = refused;
  end
endmodule

/* design/ttas_outbuf.sv */
// ----------------------------------------------------------------------------
// ttas_outbuf
// Result register with valid, refilled in the cycle its word is taken.
// ----------------------------------------------------------------------------
module ttas_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ttas_pkg::res_t res_i,
  input  logic           ready_i,
  output logic           valid_o,
  output logic           free_o,
  output ttas_pkg::res_t res_o
);
  import ttas_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

/* design/turret_aim_and_trigger_sequencer_top.sv */
// ----------------------------------------------------------------------------
// turret_aim_and_trigger_sequencer_top
// Per-tick turret loop: mode toggle, motion debounce, aim, trigger stroke and fire refusal.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  in_s      in   valid/ready      five pin levels of one tick
//  out_s     out  valid/ready      aim, trigger, auto, target, busy, refused
//  cfg       in   cfg_we_i only    cfg_idx_i selects register, cfg_data_i
//
//  one word per cycle unless out_s stalls; a result appears in the output
//  register in the cycle after its tick word is accepted
//  in_s.ready is high while the output register is empty or being taken
//  reset puts the loop state and registers at their defaults, no clearing pass
// ----------------------------------------------------------------------------
module turret_aim_and_trigger_sequencer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ttas_in_if.sink                        in_s,
  ttas_out_if.source                     out_s,
  input  logic                           cfg_we_i,
  input  logic [ttas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ttas_pkg::CFG_TW-1:0]    cfg_data_i
);
  import ttas_pkg::*;

  cfg_t cfg;
  in_t  in_word;
  res_t res_next, res_out;
  logic accept, free;

  assign in_word.mode_button_n = in_s.mode_button_n;
  assign in_word.motion_level  = in_s.motion_level;
  assign in_word.encoder_a     = in_s.encoder_a;
  assign in_word.encoder_b     = in_s.encoder_b;
  assign in_word.fire_key_n    = in_s.fire_key_n;

  assign in_s.ready = free;
  assign accept     = in_s.valid && free;

  ttas_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  ttas_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .in_i   (in_word),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  ttas_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_next),
    .ready_i (out_s.ready),
    .valid_o (out_s.valid),
    .free_o  (free),
    .res_o   (res_out)
  );

  assign out_s.aim_angle     = res_out.aim_angle;
  assign out_s.trigger_angle = res_out.trigger_angle;
  assign out_s.auto_active   = res_out.auto_active;
  assign out_s.target_seen   = res_out.target_seen;
  assign out_s.busy_res      = res_out.busy_res;
  assign out_s.fire_refused  = res_out.fire_refused;
endmodule

/* design/ttas_checker.sv */
// ----------------------------------------------------------------------------
// ttas_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ttas_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] aim_angle_i,
  input logic [7:0] trigger_angle_i,
  input logic       auto_active_i,
  input logic       busy_res_i,
  input logic       fire_refused_i
);
  import ttas_pkg::*;

  // a held result word keeps its aim, trigger and busy fields
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(aim_angle_i) &&
                                    $stable(trigger_angle_i) && $stable(busy_res_i))
    else $error("result word changed while stalled");

  // empty output register never stalls the input side
  a_free: assert property (@(posedge clk_i)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  a_aim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> aim_angle_i <= AIM_MAX_C)
    else $error("aim beyond travel");

  // trigger rests at zero while idle and on a refused fire
  a_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (!busy_res_i || fire_refused_i) |-> trigger_angle_i == 8'd0)
    else $error("trigger off zero while idle");

  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fire_refused_i |-> auto_active_i)
    else $error("refusal outside auto mode");
endmodule

bind turret_aim_and_trigger_sequencer_top ttas_checker u_ttas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_s.ready),
  .out_valid_i     (out_s.valid),
  .out_ready_i     (out_s.ready),
  .aim_angle_i     (out_s.aim_angle),
  .trigger_angle_i (out_s.trigger_angle),
  .auto_active_i   (out_s.auto_active),
  .busy_res_i      (out_s.busy_res),
  .fire_refused_i  (out_s.fire_refused)
);
